>>> hdl/cpv_pkg.sv
// Command packet validator package: verdict codes, controller states,
// control/status structs and the CRC-16 byte update. No dependencies.
package cpv_pkg;

    localparam int          RX_DATA_W   = 8;
    localparam int          TX_DATA_W   = 16;
    localparam int          INDEX_W     = 6;
    localparam int          VERDICT_W   = 3;
    localparam logic [31:0] MAGIC_RESET = 32'hC0DE_0001;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    typedef enum logic [VERDICT_W-1:0] {
        V_ACCEPT = 3'd0,
        V_LENGTH = 3'd1,
        V_MAGIC  = 3'd2,
        V_CRC    = 3'd3,
        V_REPEAT = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        S_RX,
        S_CHECK,
        S_REPLAY
    } t_state;

    typedef struct packed {
        logic accept_byte;
        logic start_replay;
        logic load_reject;
        logic load_byte;
        logic clear_pkt;
    } t_dp_cmd;

    typedef struct packed {
        logic     out_free;
        logic     idx_last;
        t_verdict verdict;
    } t_dp_status;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> hdl/cpv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/cpv_ctrl.sv
// Command packet validator controller: receive, check and replay sequencing.
// Depends on cpv_pkg.
module cpv_ctrl
    import cpv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    input  logic       i_rx_last,
    input  t_dp_status i_status,
    output logic       o_rx_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_rx_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_RX: begin
                o_rx_ready        = 1'b1;
                o_cmd.accept_byte = i_rx_valid;
                if (i_rx_valid && i_rx_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.out_free) begin
                    o_cmd.clear_pkt = 1'b1;
                    if (i_status.verdict != V_ACCEPT) begin
                        o_cmd.load_reject = 1'b1;
                        n_state           = S_RX;
                    end else begin
                        o_cmd.start_replay = 1'b1;
                        n_state            = S_REPLAY;
                    end
                end
            end
            S_REPLAY: begin
                if (i_status.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    if (i_status.idx_last) begin
                        n_state = S_RX;
                    end
                end
            end
            default: begin
                n_state = S_RX;
            end
        endcase
    end

endmodule

>>> hdl/cpv_dpath.sv
// Command packet validator datapath: packet store, CRC, field capture,
// verdict logic and output register. Depends on cpv_pkg and cpv_ram.
module cpv_dpath
    import cpv_pkg::*;
#(
    parameter int PACKET_BYTES = 36
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [RX_DATA_W-1:0]   i_rx_byte,
    input  logic                   i_cfg_wr_en,
    input  logic [31:0]            i_cfg_wr_data,
    input  logic                   i_out_ready,
    output t_dp_status             o_status,
    output logic                   o_out_valid,
    output t_verdict               o_out_verdict,
    output logic [7:0]             o_out_byte,
    output logic [INDEX_W-1:0]     o_out_index,
    output logic                   o_out_last
);

    localparam int AW = $clog2(PACKET_BYTES);
    localparam int CW = $clog2(PACKET_BYTES + 1);

    logic [31:0]   r_magic_cfg;
    logic [31:0]   r_last_seq;
    logic [CW-1:0] r_count;
    logic [15:0]   r_crc;
    logic          r_len_err;
    logic [31:0]   r_rx_magic;
    logic [31:0]   r_rx_seq;
    logic [15:0]   r_rx_crc;
    logic [AW-1:0] r_rd_idx;
    logic [AW-1:0] n_rd_idx;
    logic          r_out_valid;
    t_verdict      r_out_verdict;
    logic [7:0]    r_out_byte;
    logic [AW-1:0] r_out_index;
    logic          r_out_last;
    logic [7:0]    rd_data;
    logic          wr_en;
    logic          idx_last;
    t_verdict      verdict;

    assign wr_en    = i_cmd.accept_byte && (r_count < CW'(PACKET_BYTES));
    assign idx_last = (r_rd_idx == AW'(PACKET_BYTES - 1));

    cpv_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_addr (n_rd_idx),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_cfg <= MAGIC_RESET;
        end else if (i_cfg_wr_en) begin
            r_magic_cfg <= i_cfg_wr_data;
        end
    end

    // receive side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_crc     <= CRC_INIT;
            r_len_err <= 1'b0;
        end else if (i_cmd.clear_pkt) begin
            r_count   <= '0;
            r_crc     <= CRC_INIT;
            r_len_err <= 1'b0;
        end else if (i_cmd.accept_byte) begin
            if (wr_en) begin
                r_count <= r_count + CW'(1);
                if (r_count < CW'(PACKET_BYTES - 2)) begin
                    r_crc <= crc16_byte(r_crc, i_rx_byte);
                end
            end else begin
                r_len_err <= 1'b1;
            end
        end
    end

    // header and trailer fields, shifted in little-endian
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (r_count < CW'(4)) begin
                r_rx_magic <= {i_rx_byte, r_rx_magic[31:8]};
            end
            if (r_count >= CW'(4) && r_count < CW'(8)) begin
                r_rx_seq <= {i_rx_byte, r_rx_seq[31:8]};
            end
            if (r_count >= CW'(PACKET_BYTES - 2)) begin
                r_rx_crc <= {i_rx_byte, r_rx_crc[15:8]};
            end
        end
    end

    always_comb begin
        if (r_len_err || (r_count != CW'(PACKET_BYTES))) begin
            verdict = V_LENGTH;
        end else if (r_rx_magic != r_magic_cfg) begin
            verdict = V_MAGIC;
        end else if (r_rx_crc != r_crc) begin
            verdict = V_CRC;
        end else if (r_rx_seq == r_last_seq) begin
            verdict = V_REPEAT;
        end else begin
            verdict = V_ACCEPT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq <= '0;
        end else if (i_cmd.start_replay) begin
            r_last_seq <= r_rx_seq;
        end
    end

    // replay read address; the RAM reads the next index, so read data matches the held index
    always_comb begin
        if (i_cmd.start_replay) begin
            n_rd_idx = '0;
        end else if (i_cmd.load_byte && !idx_last) begin
            n_rd_idx = r_rd_idx + AW'(1);
        end else begin
            n_rd_idx = r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else begin
            r_rd_idx <= n_rd_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_reject || i_cmd.load_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_reject) begin
            r_out_verdict <= verdict;
            r_out_byte    <= '0;
            r_out_index   <= '0;
            r_out_last    <= 1'b1;
        end else if (i_cmd.load_byte) begin
            r_out_verdict <= V_ACCEPT;
            r_out_byte    <= rd_data;
            r_out_index   <= r_rd_idx;
            r_out_last    <= idx_last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.idx_last = idx_last;
    assign o_status.verdict  = verdict;

    assign o_out_valid   = r_out_valid;
    assign o_out_verdict = r_out_verdict;
    assign o_out_byte    = r_out_byte;
    assign o_out_index   = INDEX_W'(r_out_index);
    assign o_out_last    = r_out_last;

endmodule

>>> hdl/command_packet_validator.sv
// Command packet validator: takes one byte per cycle while receiving. After the last byte
// is taken and the output register is free, a reject verdict is loaded into that register;
// an accepted packet is instead replayed as PACKET_BYTES results, one per cycle while the
// output is not stalled. Input is held off from the last byte until the final result is
// in the output register. Synchronous active-low reset; packet store contents are not reset.
module command_packet_validator
    import cpv_pkg::*;
#(
    parameter int PACKET_BYTES = 36
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [RX_DATA_W-1:0] i_s_axis_tdata,   // [7:0] rx_byte
    input  logic                 i_s_axis_tlast,   // rx_last
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [TX_DATA_W-1:0] o_m_axis_tdata,   // [7:0] out_byte, [13:8] out_index
    output logic [VERDICT_W-1:0] o_m_axis_tuser,   // [2:0] verdict
    output logic                 o_m_axis_tlast,   // out_last
    input  logic                 i_cfg_wr_en,
    input  logic [31:0]          i_cfg_wr_data     // expected_magic
);

    t_dp_cmd            s_cmd;
    t_dp_status         s_status;
    t_verdict           s_verdict;
    logic [7:0]         s_out_byte;
    logic [INDEX_W-1:0] s_out_index;

    cpv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_s_axis_tvalid),
        .i_rx_last  (i_s_axis_tlast),
        .i_status   (s_status),
        .o_rx_ready (o_s_axis_tready),
        .o_cmd      (s_cmd)
    );

    cpv_dpath #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .i_rx_byte     (i_s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (i_m_axis_tready),
        .o_status      (s_status),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_verdict (s_verdict),
        .o_out_byte    (s_out_byte),
        .o_out_index   (s_out_index),
        .o_out_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(TX_DATA_W - 8 - INDEX_W){1'b0}}, s_out_index, s_out_byte};
    assign o_m_axis_tuser = s_verdict;

    // rejection is a single, empty, final transfer
    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != V_ACCEPT))
            |-> (o_m_axis_tlast && (o_m_axis_tdata == '0)))
        else $error("reject transfer not final or not empty");

    // replay ends on the last packet position
    a_replay_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast && (o_m_axis_tuser == V_ACCEPT))
            |-> (o_m_axis_tdata[13:8] == INDEX_W'(PACKET_BYTES - 1)))
        else $error("replay ended at wrong index");

    // no input is taken while the packet is replayed
    a_no_rx_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.load_byte || s_cmd.load_reject) |-> !o_s_axis_tready)
        else $error("input taken during verdict or replay");

endmodule

>>> tb/command_packet_validator_test.sv
// Self-checking testbench for command_packet_validator: byte stream in, verdict or replay out.
// Holds its own packet/CRC/sequence predictor; depends on cpv_pkg and the RTL only.
module command_packet_validator_test
    import cpv_pkg::*;
();

    localparam int PACKET_BYTES  = 36;
    localparam int FRAME_MAX     = 80;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 30;
    localparam int PRINT_LIMIT   = 60;

    typedef enum logic [2:0] {
        PK_GOOD,
        PK_REPEAT,
        PK_BAD_MAGIC,
        PK_BAD_CRC,
        PK_SHORT,
        PK_LONG,
        PK_NOISE
    } t_frame_kind;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    typedef struct packed {
        t_frame_kind kind;
        t_fill       fill;
        logic [6:0]  len;
        logic        typed;
        t_verdict    verdict;
    } t_row;

    typedef struct packed {
        t_verdict   verdict;
        logic [7:0] data;
        logic [5:0] idx;
        logic       last;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [RX_DATA_W-1:0] i_s_axis_tdata;    // [7:0] rx_byte
    logic                 i_s_axis_tlast;    // rx_last
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [TX_DATA_W-1:0] o_m_axis_tdata;    // [7:0] out_byte, [13:8] out_index
    logic [VERDICT_W-1:0] o_m_axis_tuser;    // [2:0] verdict
    logic                 o_m_axis_tlast;    // out_last
    logic                 i_cfg_wr_en;
    logic [31:0]          i_cfg_wr_data;     // expected_magic

    command_packet_validator #(
        .PACKET_BYTES(PACKET_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] magic_word;
    logic [31:0] accepted_seq;
    logic [7:0]  rx_buf [0:PACKET_BYTES-1];
    int          rx_count;
    logic [15:0] rx_crc;
    bit          rx_overflow;
    t_result     expected_results [$];

    logic [7:0]  frame [0:FRAME_MAX-1];
    int          frame_len;

    int          fail_count;
    int          cycle_count;
    int          sender_idle_pct;
    int          sink_stall_pct;
    logic        hold_rx;

    t_row directed_frames [5] = '{
        '{PK_REPEAT,    FILL_RANDOM, 7'd36, 1'b1, V_REPEAT},  // sequence zero right after reset
        '{PK_BAD_MAGIC, FILL_ZERO,   7'd36, 1'b1, V_MAGIC},
        '{PK_BAD_CRC,   FILL_ONES,   7'd36, 1'b1, V_CRC},
        '{PK_SHORT,     FILL_RANDOM, 7'd1,  1'b1, V_LENGTH},
        '{PK_LONG,      FILL_RANDOM, 7'd37, 1'b1, V_LENGTH}
    };

    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_LIMIT) begin
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
        end
        fail_count++;
    endtask

    // Updates packet state for one accepted byte; on the last byte queues the verdict or
    // the replay. A typed verdict, where given, replaces the computed one.
    task automatic absorb_byte(input logic [7:0] b, input logic last, input bit force_en,
                               input t_verdict forced);
        t_verdict    v;
        logic [31:0] seq_w;
        if (rx_count < PACKET_BYTES) begin
            rx_buf[rx_count] = b;
            if (rx_count < PACKET_BYTES - 2) begin
                rx_crc = crc_ccitt_step(rx_crc, b);
            end
            rx_count++;
        end else begin
            rx_overflow = 1'b1;
        end
        if (!last) begin
            return;
        end
        seq_w = {rx_buf[7], rx_buf[6], rx_buf[5], rx_buf[4]};
        if (rx_overflow || rx_count != PACKET_BYTES) begin
            v = V_LENGTH;
        end else if ({rx_buf[3], rx_buf[2], rx_buf[1], rx_buf[0]} != magic_word) begin
            v = V_MAGIC;
        end else if ({rx_buf[PACKET_BYTES-1], rx_buf[PACKET_BYTES-2]} != rx_crc) begin
            v = V_CRC;
        end else if (seq_w == accepted_seq) begin
            v = V_REPEAT;
        end else begin
            v = V_ACCEPT;
        end
        if (force_en) begin
            v = forced;
        end
        if (v != V_ACCEPT) begin
            expected_results.push_back('{v, 8'h00, 6'd0, 1'b1});
        end else begin
            accepted_seq = seq_w;
            for (int i = 0; i < PACKET_BYTES; i++) begin
                expected_results.push_back('{V_ACCEPT, rx_buf[i], i[5:0],
                                             i == PACKET_BYTES - 1});
            end
        end
        rx_count    = 0;
        rx_crc      = CRC_INIT;
        rx_overflow = 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input bit force_en,
                             input t_verdict forced);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        absorb_byte(b, last, force_en, forced);
    endtask

    function automatic logic [7:0] fill_byte(input t_fill fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic build_frame(input t_frame_kind kind, input int len, input t_fill fill);
        logic [31:0] seq;
        logic [15:0] crc;
        int          pos;
        case (fill)
            FILL_ZERO: seq = 32'h0000_0001;
            FILL_ONES: seq = 32'hFFFF_FFFF;
            default:   seq = $urandom;
        endcase
        if (seq == accepted_seq) begin
            seq = seq + 32'd1;
        end
        if (kind == PK_REPEAT) begin
            seq = accepted_seq;
        end
        {frame[3], frame[2], frame[1], frame[0]} = magic_word;
        {frame[7], frame[6], frame[5], frame[4]} = seq;
        for (int i = 8; i < PACKET_BYTES - 2; i++) begin
            frame[i] = fill_byte(fill);
        end
        if (kind == PK_BAD_MAGIC) begin
            pos = $urandom_range(3);
            frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(7));
        end
        crc = CRC_INIT;
        for (int i = 0; i < PACKET_BYTES - 2; i++) begin
            crc = crc_ccitt_step(crc, frame[i]);
        end
        frame[PACKET_BYTES-2] = crc[7:0];
        frame[PACKET_BYTES-1] = crc[15:8];
        if (kind == PK_BAD_CRC) begin
            pos = PACKET_BYTES - 2 + $urandom_range(1);
            frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(7));
        end
        frame_len = PACKET_BYTES;
        if (kind == PK_SHORT || kind == PK_LONG || kind == PK_NOISE) begin
            frame_len = len;
        end
        for (int i = PACKET_BYTES; i < frame_len; i++) begin
            frame[i] = fill_byte(fill);
        end
        if (kind == PK_NOISE) begin
            for (int i = 0; i < frame_len; i++) begin
                frame[i] = 8'($urandom_range(255));
            end
        end
    endtask

    task automatic send_frame(input bit force_en, input t_verdict forced);
        for (int i = 0; i < frame_len; i++) begin
            send_byte(frame[i], i == frame_len - 1, force_en, forced);
        end
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_magic(input logic [31:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        magic_word = value;
    endtask

    // Mostly well-formed packets with random content; the rest corrupt, cut, overlong or noise.
    task automatic run_random(input int byte_goal);
        int          sent;
        int          r;
        int          len;
        t_frame_kind kind;
        sent = 0;
        while (sent < byte_goal) begin
            r   = $urandom_range(99);
            len = PACKET_BYTES;
            if (r < 55) begin
                kind = PK_GOOD;
            end else if (r < 65) begin
                kind = PK_REPEAT;
            end else if (r < 73) begin
                kind = PK_BAD_MAGIC;
            end else if (r < 81) begin
                kind = PK_BAD_CRC;
            end else if (r < 88) begin
                kind = PK_SHORT;
                len  = $urandom_range(PACKET_BYTES - 1, 1);
            end else if (r < 94) begin
                kind = PK_LONG;
                len  = $urandom_range(FRAME_MAX, PACKET_BYTES + 1);
            end else begin
                kind = PK_NOISE;
                len  = $urandom_range(FRAME_MAX, 1);
            end
            build_frame(kind, len, FILL_RANDOM);
            send_frame(1'b0, V_ACCEPT);
            sent += frame_len;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected transfer", 32'(o_m_axis_tdata), 32'd0);
            return;
        end
        want = expected_results.pop_front();
        if (o_m_axis_tuser !== want.verdict) begin
            report_mismatch("verdict", 32'(o_m_axis_tuser), 32'(want.verdict));
        end
        if (o_m_axis_tdata[7:0] !== want.data) begin
            report_mismatch("out_byte", 32'(o_m_axis_tdata[7:0]), 32'(want.data));
        end
        if (o_m_axis_tdata[13:8] !== want.idx) begin
            report_mismatch("out_index", 32'(o_m_axis_tdata[13:8]), 32'(want.idx));
        end
        if (o_m_axis_tlast !== want.last) begin
            report_mismatch("out_last", 32'(o_m_axis_tlast), 32'(want.last));
        end
    endtask

    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                check_result();
            end
            i_m_axis_tready <= !hold_rx && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [31:0] phase_magic;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        hold_rx         <= 1'b0;
        sink_stall_pct  <= 0;
        sender_idle_pct = 0;
        fail_count      = 0;
        magic_word      = MAGIC_RESET;
        accepted_seq    = '0;
        rx_count        = 0;
        rx_crc          = CRC_INIT;
        rx_overflow     = 1'b0;
        for (int i = 0; i < PACKET_BYTES; i++) begin
            rx_buf[i] = 8'h00;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows and the stall run make up the phase with no idling
        foreach (directed_frames[r]) begin
            build_frame(directed_frames[r].kind, int'(directed_frames[r].len),
                        directed_frames[r].fill);
            send_frame(directed_frames[r].typed, directed_frames[r].verdict);
        end

        // output held off long enough that the block fills and stalls its input
        wait_idle();
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        build_frame(PK_GOOD, PACKET_BYTES, FILL_ONES);
        send_frame(1'b0, V_ACCEPT);
        build_frame(PK_SHORT, 1, FILL_RANDOM);
        send_frame(1'b0, V_ACCEPT);

        for (int p = 0; p < 3; p++) begin
            case (p)
                0:       phase_magic = 32'h0000_0000;
                1:       phase_magic = 32'hFFFF_FFFF;
                default: phase_magic = $urandom;
            endcase
            write_magic(phase_magic);
            case (p)
                0: begin
                    sender_idle_pct = 79;
                    sink_stall_pct <= 0;
                end
                1: begin
                    sender_idle_pct = 0;
                    sink_stall_pct <= 79;
                end
                default: begin
                    sender_idle_pct = 11;
                    sink_stall_pct <= 11;
                end
            endcase
            run_random(PHASE_BYTES);
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
